>>> hw/rtl/client_key_id_map_defines.svh
// ----------------------------------------------------------------------------
// client_key_id_map_defines: assertion macros included by ckm_datapath, the one user among the rtl files
// ----------------------------------------------------------------------------
`ifndef CLIENT_KEY_ID_MAP_DEFINES_SVH
`define CLIENT_KEY_ID_MAP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CKM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CKM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ckm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckm_pkg: shared types and constants for the key-to-slot map
// transaction payloads, controller states, command and status groups
// ----------------------------------------------------------------------------
package ckm_pkg;

    localparam int unsigned SLOT_COUNT   = 64;
    localparam int unsigned SLOT_W       = $clog2(SLOT_COUNT);
    localparam int unsigned CNT_W        = $clog2(SLOT_COUNT + 1);
    localparam int unsigned SLOT_FIELD_W = 6;
    localparam int unsigned KEY_HALF_W   = 64;

    typedef logic [SLOT_W-1:0] slot_idx_t;
    typedef logic [CNT_W-1:0]  slot_cnt_t;

    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] hint_slot;
        logic [KEY_HALF_W-1:0]   fsid_high;
        logic [KEY_HALF_W-1:0]   fsid_low;
        logic [KEY_HALF_W-1:0]   global_key;
    } req_t;

    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] slot;
        logic                    was_present;
        logic                    reused_first;
    } rsp_t;

    typedef struct packed {
        logic [KEY_HALF_W-1:0] fsid_high;
        logic [KEY_HALF_W-1:0] fsid_low;
        logic [KEY_HALF_W-1:0] global_key;
    } key_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HINT,
        ST_HCMP,
        ST_SCAN,
        ST_ALLOC,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic addr_one;
        logic addr_inc;
        logic hit_take;
        logic alloc;
        logic load_out;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hint_ok;
        logic hit;
        logic last_zero;
        logic at_last;
        logic out_free;
    } dp_stat_t;

endpackage

>>> hw/rtl/client_key_id_map.sv
// sequence: accept, hint read, hint compare, then result load on a hint hit; otherwise a scan
//   of slots from 1 up to a hit or the newest slot, an allocation on a miss, then result load
// throughput: one transaction at a time; the next is taken in the cycle after the result is
//   loaded, set by the key store's single read port, read once per cycle during the scan
// reset: asynchronous, clears the slot valid bits, the allocation counter and all control
//   state at once, so every slot reads as an all-zero key right after reset
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// client_key_id_map: maps a 192-bit client key to a small slot number
// checks the hinted slot, then scans allocated slots from 1 upward, and on a
// miss allocates the next slot (slot 1 is reused once the slots run out)
// ----------------------------------------------------------------------------
module client_key_id_map (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ckm_pkg::req_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output ckm_pkg::rsp_t  out_data
);
    import ckm_pkg::*;

    // command and status groups between the sequencer and the datapath
    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // sequencer: idle, hint read, hint compare, scan, allocate, result load
    ckm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: key store with valid bits, comparator, counter, output register
    // the output register lets a finished result wait while the next
    // transaction is accepted and worked on
    ckm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> hw/rtl/ckm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckm_datapath: key store, scan compare, allocation and result register
// one registered store read per cycle, compare on the registered word
// ----------------------------------------------------------------------------
`include "client_key_id_map_defines.svh"

module ckm_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  ckm_pkg::req_t      in_data,
    input  ckm_pkg::ctrl_cmd_t cmd,
    output ckm_pkg::dp_stat_t  stat,
    output logic               out_valid,
    input  logic               out_ready,
    output ckm_pkg::rsp_t      out_data
);
    import ckm_pkg::*;

    localparam int unsigned ADDR_CMP_W = SLOT_W + 1;
    localparam int unsigned HINT_CMP_W = SLOT_FIELD_W + CNT_W;

    key_t            mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] valid_reg;

    req_t       req_reg;
    logic       hint_ok_reg;
    slot_idx_t  addr_reg;
    slot_idx_t  cmp_addr_reg;
    key_t       rd_key_reg;
    logic       rd_valid_reg;
    slot_cnt_t  used_reg;
    slot_cnt_t  used_next;
    slot_idx_t  last_slot;
    slot_idx_t  alloc_slot;
    logic       alloc_reuse;
    logic       addr_in_range;
    logic       hint_ok_next;
    key_t       req_key;
    key_t       rd_key;

    slot_idx_t  res_slot_reg;
    logic       res_present_reg;
    logic       res_reused_reg;

    logic       out_valid_reg;
    rsp_t       out_reg;

    assign req_key = '{fsid_high:  req_reg.fsid_high,
                       fsid_low:   req_reg.fsid_low,
                       global_key: req_reg.global_key};

    // never-written entries read back as zero
    assign rd_key = rd_valid_reg ? rd_key_reg : '0;

    assign addr_in_range = ADDR_CMP_W'(addr_reg) < ADDR_CMP_W'(SLOT_COUNT);

    assign hint_ok_next = (in_data.hint_slot != '0)
                       && (HINT_CMP_W'(in_data.hint_slot) < HINT_CMP_W'(SLOT_COUNT));

    // scan stops at the newest slot, capped below the slot count
    assign last_slot = (used_reg > CNT_W'(SLOT_COUNT - 1))
                     ? SLOT_W'(SLOT_COUNT - 1) : SLOT_W'(used_reg);

    // allocation counter saturates, then slot 1 takes the overflow
    assign used_next   = (used_reg < CNT_W'(SLOT_COUNT)) ? used_reg + CNT_W'(1) : used_reg;
    assign alloc_reuse = used_next >= CNT_W'(SLOT_COUNT);
    assign alloc_slot  = alloc_reuse ? SLOT_W'(1) : SLOT_W'(used_next);

    assign stat.hint_ok   = hint_ok_reg;
    assign stat.hit       = (rd_key == req_key);
    assign stat.last_zero = (last_slot == '0);
    assign stat.at_last   = (cmp_addr_reg == last_slot);
    assign stat.out_free  = !out_valid_reg || out_ready;

    // store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.alloc)
        begin
            mem[alloc_slot] <= req_key;
        end
        if (addr_in_range)
        begin
            rd_key_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            used_reg     <= '0;
        end
        else
        begin
            rd_valid_reg <= addr_in_range ? valid_reg[addr_reg] : 1'b0;
            if (cmd.alloc)
            begin
                valid_reg[alloc_slot] <= 1'b1;
                used_reg              <= used_next;
            end
        end
    end

    // request capture, scan address and result
    always_ff @(posedge clk)
    begin
        cmp_addr_reg <= addr_reg;
        if (cmd.capture)
        begin
            req_reg     <= in_data;
            hint_ok_reg <= hint_ok_next;
            addr_reg    <= SLOT_W'(in_data.hint_slot);
        end
        else if (cmd.addr_one)
        begin
            addr_reg <= SLOT_W'(1);
        end
        else if (cmd.addr_inc)
        begin
            addr_reg <= addr_reg + SLOT_W'(1);
        end

        if (cmd.hit_take)
        begin
            res_slot_reg    <= cmp_addr_reg;
            res_present_reg <= 1'b1;
            res_reused_reg  <= 1'b0;
        end
        else if (cmd.alloc)
        begin
            res_slot_reg    <= alloc_slot;
            res_present_reg <= 1'b0;
            res_reused_reg  <= alloc_reuse;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg.slot         <= SLOT_FIELD_W'(res_slot_reg);
            out_reg.was_present  <= res_present_reg;
            out_reg.reused_first <= res_reused_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `CKM_ASSERT_NOW(a_used_bounded, 1'b1, used_reg <= CNT_W'(SLOT_COUNT), "slot counter overran")
    `CKM_ASSERT_NEXT(a_alloc_marks_valid, cmd.alloc, valid_reg[res_slot_reg], "allocated slot not marked valid")
    `CKM_ASSERT_NOW(a_result_nonzero, cmd.load_out, res_slot_reg != '0, "result slot is zero")
    `CKM_ASSERT_NOW(a_load_has_room, cmd.load_out, !out_valid_reg || out_ready, "output overwritten while held")

endmodule

>>> hw/rtl/ckm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckm_ctrl: sequencer for hint check, slot scan and allocation
// drives the datapath through a command group, reads back its status
// ----------------------------------------------------------------------------
module ckm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ckm_pkg::dp_stat_t  stat,
    output ckm_pkg::ctrl_cmd_t cmd
);
    import ckm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_HINT;
                end
            end
            // hint word is being read, queue slot 1 behind it
            ST_HINT:
            begin
                cmd.addr_one = 1'b1;
                state_next   = ST_HCMP;
            end
            ST_HCMP:
            begin
                if (stat.hint_ok && stat.hit)
                begin
                    cmd.hit_take = 1'b1;
                    state_next   = ST_DONE;
                end
                else if (stat.last_zero)
                begin
                    state_next = ST_ALLOC;
                end
                else
                begin
                    cmd.addr_inc = 1'b1;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.hit)
                begin
                    cmd.hit_take = 1'b1;
                    state_next   = ST_DONE;
                end
                else if (stat.at_last)
                begin
                    state_next = ST_ALLOC;
                end
                else
                begin
                    cmd.addr_inc = 1'b1;
                end
            end
            ST_ALLOC:
            begin
                cmd.alloc  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
